@@ src/ilid_pkg.sv @@
`timescale 1ns / 1ps

package ilid_pkg;

   localparam int DATA_W   = 32;
   localparam int FUNC_W   = 2;
   localparam int POS_W    = 7;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 7;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_INSERT = 2'd0,
      FUNC_DELETE = 2'd1,
      FUNC_READ   = 2'd2
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_RANGE = 2'd1,
      STATUS_FULL  = 2'd2
   } status_type;

   typedef struct packed {
      logic ins_en;
      logic del_en;
      logic rd_en;
   } cell_ctrl_type;

endpackage

@@ src/indexed_list_insert_delete_unit.sv @@
`timescale 1ns / 1ps

// Ordered list of up to DEPTH signed 32-bit entries kept in a row of cells
// with a live count. Insert (func 0) places req_value at req_position and
// shifts later entries up; delete (func 1) removes the entry at req_position
// and shifts later entries down; read (func 2) returns the entry at
// req_position. Every command answers with one result: status (0 ok,
// 1 position out of range, 2 full), the count after the command in its low
// 7 bits, and the read value (zero unless a good read). All cells shift
// together in the cycle of the transfer, and the result lands in an output
// register, so a new command is taken every cycle while the result side
// keeps up. Entries at or above the count hold no meaningful data and are
// never returned.
module indexed_list_insert_delete_unit #(
   parameter int DEPTH = 64
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [ilid_pkg::FUNC_W-1:0]          req_func,
   input  logic [ilid_pkg::POS_W-1:0]           req_position,
   input  logic signed [ilid_pkg::DATA_W-1:0]   req_value,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [ilid_pkg::STATUS_W-1:0]        rsp_status,
   output logic [ilid_pkg::COUNT_W-1:0]         rsp_count,
   output logic signed [ilid_pkg::DATA_W-1:0]   rsp_read_value
);
   import ilid_pkg::*;

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

   logic [CNT_W-1:0]         count_ff;
   logic [CNT_W-1:0]         count_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   status_type               status_ff;
   status_type               status_in;
   logic [COUNT_W-1:0]       rsp_count_ff;
   logic signed [DATA_W-1:0] read_value_ff;
   logic signed [DATA_W-1:0] read_value_in;

   logic                     accept;
   logic [CMP_W-1:0]         pos_x;
   logic [CMP_W-1:0]         cnt_x;
   cell_ctrl_type            ctrl;
   logic signed [DATA_W-1:0] read_any;

   logic signed [DATA_W-1:0] cell_data [DEPTH];
   logic signed [DATA_W-1:0] cell_rd   [DEPTH];

   // hold the result register until it is taken; accept when it frees up
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign accept    = req_valid && req_ready;
   assign pos_x     = CMP_W'(req_position);
   assign cnt_x     = CMP_W'(count_ff);

   genvar gi;
   generate
      for (gi = 0; gi < DEPTH; gi++) begin : g_cell
         logic signed [DATA_W-1:0] prev_d;
         logic signed [DATA_W-1:0] next_d;
         if (gi == 0) begin : g_first
            assign prev_d = req_value;
         end else begin : g_mid_p
            assign prev_d = cell_data[gi-1];
         end
         if (gi == DEPTH - 1) begin : g_last
            assign next_d = '0;
         end else begin : g_mid_n
            assign next_d = cell_data[gi+1];
         end
         ilid_cell #(
            .CMP_W      (CMP_W),
            .CELL_INDEX (gi)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl),
            .pos       (pos_x),
            .ins_value (req_value),
            .prev_data (prev_d),
            .next_data (next_d),
            .data      (cell_data[gi]),
            .rd_data   (cell_rd[gi])
         );
      end
   endgenerate

   always_comb begin
      read_any = '0;
      for (int i = 0; i < DEPTH; i++) begin
         read_any = read_any | cell_rd[i];
      end
   end

   always_comb begin
      ctrl          = '0;
      count_in      = count_ff;
      status_in     = STATUS_OK;
      read_value_in = '0;
      case (func_type'(req_func))
         FUNC_INSERT: begin
            if (pos_x > cnt_x) begin
               status_in = STATUS_RANGE;
            end else if (count_ff == CNT_W'(DEPTH)) begin
               status_in = STATUS_FULL;
            end else begin
               ctrl.ins_en = accept;
               count_in    = count_ff + 1'b1;
            end
         end
         FUNC_DELETE: begin
            if (pos_x >= cnt_x) begin
               status_in = STATUS_RANGE;
            end else begin
               ctrl.del_en = accept;
               count_in    = count_ff - 1'b1;
            end
         end
         FUNC_READ: begin
            if (pos_x >= cnt_x) begin
               status_in = STATUS_RANGE;
            end else begin
               ctrl.rd_en    = 1'b1;
               read_value_in = read_any;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (accept) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            count_ff <= count_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         status_ff     <= status_in;
         rsp_count_ff  <= COUNT_W'(count_in);
         read_value_ff <= read_value_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_count      = rsp_count_ff;
   assign rsp_read_value = read_value_ff;

endmodule

@@ src/ilid_cell.sv @@
`timescale 1ns / 1ps

module ilid_cell #(
   parameter int CMP_W      = 8,
   parameter int CELL_INDEX = 0
) (
   input  logic                              clock,
   input  ilid_pkg::cell_ctrl_type           ctrl,
   input  logic [CMP_W-1:0]                  pos,
   input  logic signed [ilid_pkg::DATA_W-1:0] ins_value,
   input  logic signed [ilid_pkg::DATA_W-1:0] prev_data,
   input  logic signed [ilid_pkg::DATA_W-1:0] next_data,
   output logic signed [ilid_pkg::DATA_W-1:0] data,
   output logic signed [ilid_pkg::DATA_W-1:0] rd_data
);
   import ilid_pkg::*;

   localparam logic [CMP_W-1:0] MyIndex = CMP_W'(CELL_INDEX);

   logic signed [DATA_W-1:0] data_ff;
   logic signed [DATA_W-1:0] data_in;

   always_comb begin
      data_in = data_ff;
      if (ctrl.ins_en) begin
         if (MyIndex == pos) begin
            data_in = ins_value;
         end else if (MyIndex > pos) begin
            data_in = prev_data;
         end
      end else if (ctrl.del_en) begin
         // move the later entries down over the deleted one
         if (MyIndex >= pos) begin
            data_in = next_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data    = data_ff;
   assign rd_data = (ctrl.rd_en && (MyIndex == pos)) ? data_ff : '0;

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 1ps

module tb_top;
   import ilid_pkg::*;

   localparam int LIST_DEPTH = 64;
   localparam int CYCLE_LIMIT = 250000;
   localparam int ITEMS_PER_PHASE = 134;
   localparam int DRILL_LEN = 23;
   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;

   typedef struct packed {
      logic [STATUS_W-1:0]      status;
      logic [COUNT_W-1:0]       count;
      logic signed [DATA_W-1:0] rdata;
   } list_rsp_type;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic [POS_W-1:0]         pos;
      logic signed [DATA_W-1:0] value;
      logic                     typed;
      list_rsp_type             want;
   } cmd_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_ready;
   logic [FUNC_W-1:0]        req_func = FUNC_INSERT;
   logic [POS_W-1:0]         req_position = '0;
   logic signed [DATA_W-1:0] req_value = '0;
   logic                     rsp_valid;
   logic                     rsp_ready = 1'b0;
   logic [STATUS_W-1:0]      rsp_status;
   logic [COUNT_W-1:0]       rsp_count;
   logic signed [DATA_W-1:0] rsp_read_value;

   // shadow copy of the list
   logic signed [DATA_W-1:0] list_cells [LIST_DEPTH];
   int                       list_held = 0;

   list_rsp_type pending_rsp_q [$];
   int           fail_count = 0;
   int           tx_idle_pct = 0;
   int           rx_idle_pct = 0;
   int unsigned  cycle_count = 0;

   // typed expectations only where they are obvious; the rest come from the predictor
   cmd_row_type drill_rows [DRILL_LEN] = '{
      '{FUNC_READ,   7'd0,   32'sd0,        1'b1, '{STATUS_RANGE, 7'd0, 32'sd0}},
      '{FUNC_DELETE, 7'd0,   32'sd0,        1'b1, '{STATUS_RANGE, 7'd0, 32'sd0}},
      '{FUNC_INSERT, 7'd1,   32'sd5,        1'b1, '{STATUS_RANGE, 7'd0, 32'sd0}},
      '{FUNC_UNUSED, 7'd127, -32'sd1,       1'b1, '{STATUS_OK,    7'd0, 32'sd0}},
      '{FUNC_INSERT, 7'd0,   32'h7fffffff,  1'b1, '{STATUS_OK,    7'd1, 32'sd0}},
      '{FUNC_INSERT, 7'd0,   32'h80000000,  1'b1, '{STATUS_OK,    7'd2, 32'sd0}},
      '{FUNC_INSERT, 7'd2,   -32'sd1,       1'b1, '{STATUS_OK,    7'd3, 32'sd0}},
      '{FUNC_READ,   7'd0,   32'sd0,        1'b1, '{STATUS_OK,    7'd3, 32'h80000000}},
      '{FUNC_READ,   7'd2,   32'h7fffffff,  1'b1, '{STATUS_OK,    7'd3, -32'sd1}},
      '{FUNC_INSERT, 7'd127, 32'sd0,        1'b1, '{STATUS_RANGE, 7'd3, 32'sd0}},
      '{FUNC_READ,   7'd127, 32'sd0,        1'b1, '{STATUS_RANGE, 7'd3, 32'sd0}},
      '{FUNC_DELETE, 7'd3,   32'sd0,        1'b1, '{STATUS_RANGE, 7'd3, 32'sd0}},
      '{FUNC_READ,   7'd3,   32'sd0,        1'b1, '{STATUS_RANGE, 7'd3, 32'sd0}},
      '{FUNC_INSERT, 7'd3,   32'sd0,        1'b1, '{STATUS_OK,    7'd4, 32'sd0}},
      '{FUNC_INSERT, 7'd1,   32'h5a5a5a5a,  1'b0, '0},
      '{FUNC_READ,   7'd1,   32'sd0,        1'b0, '0},
      '{FUNC_READ,   7'd2,   32'sd0,        1'b0, '0},
      '{FUNC_DELETE, 7'd0,   32'sd0,        1'b0, '0},
      '{FUNC_READ,   7'd0,   32'sd0,        1'b0, '0},
      '{FUNC_DELETE, 7'd3,   32'sd0,        1'b0, '0},
      '{FUNC_UNUSED, 7'd0,   32'h12345678,  1'b0, '0},
      '{FUNC_READ,   7'd1,   32'sd0,        1'b0, '0},
      '{FUNC_DELETE, 7'd0,   32'sd0,        1'b0, '0}
   };

   indexed_list_insert_delete_unit #(
      .DEPTH(LIST_DEPTH)
   ) i_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_func      (req_func),
      .req_position  (req_position),
      .req_value     (req_value),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_status    (rsp_status),
      .rsp_count     (rsp_count),
      .rsp_read_value(rsp_read_value)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // apply one command to the shadow list and return what the block should answer
   function automatic list_rsp_type apply_list_cmd(input logic [FUNC_W-1:0] f,
                                                   input logic [POS_W-1:0] p,
                                                   input logic signed [DATA_W-1:0] v);
      list_rsp_type r;
      int           i;
      r = '0;
      r.status = STATUS_OK;
      case (f)
         FUNC_INSERT: begin
            if (p > list_held) begin
               r.status = STATUS_RANGE;
            end else if (list_held >= LIST_DEPTH) begin
               r.status = STATUS_FULL;
            end else begin
               for (i = list_held; i > p; i--) list_cells[i] = list_cells[i-1];
               list_cells[p] = v;
               list_held++;
            end
         end
         FUNC_DELETE: begin
            if (p >= list_held) begin
               r.status = STATUS_RANGE;
            end else begin
               for (i = p; i + 1 < list_held; i++) list_cells[i] = list_cells[i+1];
               list_held--;
            end
         end
         FUNC_READ: begin
            if (p >= list_held) r.status = STATUS_RANGE;
            else r.rdata = list_cells[p];
         end
         default: ;
      endcase
      r.count = list_held[COUNT_W-1:0];
      return r;
   endfunction

   // caller stands at a rising edge; returns at the edge of the transfer
   task automatic issue_cmd(input logic [FUNC_W-1:0] f, input logic [POS_W-1:0] p,
                            input logic signed [DATA_W-1:0] v, input logic typed,
                            input list_rsp_type typed_rsp);
      list_rsp_type predicted;
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid    <= 1'b1;
      req_func     <= f;
      req_position <= p;
      req_value    <= v;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = apply_list_cmd(f, p, v);
      pending_rsp_q.push_back(typed ? typed_rsp : predicted);
   endtask

   task automatic hold_until_drained();
      if (req_valid) req_valid <= 1'b0;
      while (pending_rsp_q.size() != 0) @(posedge clock);
   endtask

   task automatic check_field(input string what, input logic [DATA_W-1:0] want,
                              input logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s expected %0h actual %0h", $time, what, want, got);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      list_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_rsp_q.size() == 0) begin
            $display("%0t: result with nothing expected, status %0d count %0d value %0h",
                     $time, rsp_status, rsp_count, rsp_read_value);
            fail_count++;
         end else begin
            want = pending_rsp_q.pop_front();
            check_field("status", want.status, rsp_status);
            check_field("count", want.count, rsp_count);
            check_field("read_value", want.rdata, rsp_read_value);
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_rsp_q.size());
         $display("tb_top NOT OK");
         $finish;
      end
   end

   initial begin
      int                       phase;
      int                       n;
      int                       roll;
      int                       lim;
      int                       full_tries;
      logic                     growing;
      logic [FUNC_W-1:0]        f;
      logic [POS_W-1:0]         p;
      logic signed [DATA_W-1:0] v;

      growing = 1'b1;
      full_tries = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 7 : (phase == 1) ? 79 : 0;
         rx_idle_pct = (phase == 0) ? 79 : (phase == 1) ? 7 : 0;

         if (phase == 0) begin
            for (n = 0; n < DRILL_LEN; n++) begin
               issue_cmd(drill_rows[n].func, drill_rows[n].pos, drill_rows[n].value,
                         drill_rows[n].typed, drill_rows[n].want);
            end
         end

         for (n = 0; n < ITEMS_PER_PHASE; n++) begin
            // fill until full and a few full inserts are seen, then drain to empty
            if (growing && list_held == LIST_DEPTH && full_tries >= 3) begin
               growing = 1'b0;
            end else if (!growing && list_held == 0) begin
               growing = 1'b1;
               full_tries = 0;
            end

            roll = $urandom_range(99);
            if (roll < 3) f = FUNC_UNUSED;
            else if (roll < 13) f = FUNC_READ;
            else if (roll < (growing ? 90 : 23)) f = FUNC_INSERT;
            else f = FUNC_DELETE;
            if (f == FUNC_INSERT && list_held == LIST_DEPTH) full_tries++;

            lim = (f == FUNC_INSERT) ? list_held : list_held - 1;
            roll = $urandom_range(9);
            if (roll == 0 || lim < 0) p = POS_W'($urandom_range(127));
            else if (roll == 1) p = '0;
            else if (roll == 2) p = POS_W'(lim);
            else p = POS_W'($urandom_range(lim, 0));

            roll = $urandom_range(15);
            if (roll == 0) v = 32'h80000000;
            else if (roll == 1) v = 32'h7fffffff;
            else if (roll == 2) v = '0;
            else if (roll == 3) v = -32'sd1;
            else v = $urandom;

            issue_cmd(f, p, v, 1'b0, '0);
            if ($urandom_range(199) == 0) hold_until_drained();
         end
         hold_until_drained();
      end

      repeat (8) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb_top OK");
      end else begin
         $display("tb_top NOT OK");
      end
      $finish;
   end

endmodule
